[sv/scalar_kalman_filter_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the scalar Kalman filter
// Implication helpers, clocked on clk and idle while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SCALAR_KALMAN_FILTER_TOP_ASSERT_SVH
`define SCALAR_KALMAN_FILTER_TOP_ASSERT_SVH

// same-cycle implication
`define SKF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SKF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/skf_pkg.sv]
// ----------------------------------------------------------------------------
// skf_pkg
// Types and constants shared by the scalar Kalman filter and its checker.
// ----------------------------------------------------------------------------
package skf_pkg;

    localparam int unsigned IN_DATA_W  = 64;
    localparam int unsigned OUT_DATA_W = 96;

    // result field positions in m_axis_tdata
    localparam int unsigned EST_LSB = 0;
    localparam int unsigned VAR_LSB = 32;
    localparam int unsigned NIS_LSB = 64;

    localparam logic [31:0] PROCESS_NOISE_RST = 32'd655;
    localparam logic [31:0] VARIANCE_RST      = 32'h0001_0000;
    localparam logic [16:0] ONE_Q16           = 17'h1_0000;

    localparam int unsigned CNT_W         = 6;
    localparam logic [CNT_W-1:0] K_STEPS   = CNT_W'(17);
    localparam logic [CNT_W-1:0] NIS_STEPS = CNT_W'(32);

    localparam logic KIND_PREDICT = 1'b0;
    localparam logic KIND_UPDATE  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_K,
        ST_MUL_STEP,
        ST_MUL_VAR,
        ST_MUL_NIS,
        ST_NIS_CHK,
        ST_DIV_NIS,
        ST_DONE
    } skf_state_t;

endpackage

[sv/scalar_kalman_filter_top.sv]
// Predict goes from input transfer to ST_DONE, which parks the result. Update
// runs the gain divide (17 steps), the multiply/check states and the NIS divide
// (32 steps), skipping the NIS divide when NIS saturates and all of them when
// S is zero. One item in flight; the next is taken the cycle after the result
// is parked. The shared restoring divider gives one quotient bit per cycle.
// Reset (rst_n low, async): estimate 0, variance 1.0, process noise 655, idle.
// ----------------------------------------------------------------------------
// scalar_kalman_filter_top
// One-dimensional Kalman filter in Q16.16 with a shared divider and multiplier.
// ----------------------------------------------------------------------------
module scalar_kalman_filter_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          process_noise_wr_en,
    input  logic [31:0]                   process_noise_wr_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [31:0] measurement, [63:32] measurement_variance
    input  logic [skf_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // [0] kind
    input  logic                          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [31:0] estimate, [63:32] variance, [95:64] nis
    output logic [skf_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // [0] error
    output logic                          m_axis_tuser
);
    import skf_pkg::*;

    skf_state_t        state_reg, state_next;
    logic [31:0]       pn_reg, pn_next;
    logic [31:0]       est_reg, est_next;
    logic [31:0]       var_reg, var_next;
    logic              out_valid_reg, out_valid_next;

    logic [32:0]       s_reg, s_next;
    logic [31:0]       mag_reg, mag_next;
    logic              neg_reg, neg_next;
    logic [16:0]       k_reg, k_next;
    logic [32:0]       rem_reg, rem_next;
    logic [63:0]       dsr_reg, dsr_next;
    logic [31:0]       quo_reg, quo_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [63:0]       prod_reg;
    logic [31:0]       nis_reg, nis_next;
    logic              err_reg, err_next;
    logic [31:0]       out_est_reg, out_est_next;
    logic [31:0]       out_var_reg, out_var_next;
    logic [31:0]       out_nis_reg, out_nis_next;
    logic              out_err_reg, out_err_next;

    logic [31:0]       meas;
    logic [31:0]       mvar;
    logic [32:0]       s_sum;
    logic [32:0]       innov;
    logic [32:0]       innov_neg;
    logic [32:0]       pred_sum;
    logic [33:0]       rem_sh;
    logic              div_ge;
    logic [33:0]       rem_sub;
    logic [31:0]       mul_a;
    logic [31:0]       mul_b;
    logic [31:0]       step;
    logic [33:0]       est_ext;
    logic [33:0]       est_sum;
    logic [16:0]       one_minus_k;
    logic              out_free;

    assign meas      = s_axis_tdata[31:0];
    assign mvar      = s_axis_tdata[63:32];
    assign s_sum     = {1'b0, var_reg} + {1'b0, mvar};
    assign innov     = {meas[31], meas} - {est_reg[31], est_reg};
    assign innov_neg = 33'd0 - innov;
    assign pred_sum  = {1'b0, var_reg} + {1'b0, pn_reg};

    // shared restoring divider step: one quotient bit per cycle
    assign rem_sh  = {rem_reg, dsr_reg[63]};
    assign div_ge  = rem_sh >= {1'b0, s_reg};
    assign rem_sub = rem_sh - {1'b0, s_reg};

    assign step        = prod_reg[47:16];
    assign est_ext     = {{2{est_reg[31]}}, est_reg};
    assign est_sum     = neg_reg ? (est_ext - {2'b00, step}) : (est_ext + {2'b00, step});
    assign one_minus_k = ONE_Q16 - k_reg;
    assign out_free    = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        state_next     = state_reg;
        pn_next        = process_noise_wr_en ? process_noise_wr_data : pn_reg;
        est_next       = est_reg;
        var_next       = var_reg;
        out_valid_next = (out_valid_reg && !m_axis_tready) ? 1'b1 : 1'b0;
        s_next         = s_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        k_next         = k_reg;
        rem_next       = div_ge ? rem_sub[32:0] : rem_sh[32:0];
        dsr_next       = {dsr_reg[62:0], 1'b0};
        quo_next       = {quo_reg[30:0], div_ge};
        cnt_next       = cnt_reg - CNT_W'(1);
        nis_next       = nis_reg;
        err_next       = err_reg;
        out_est_next   = out_est_reg;
        out_var_next   = out_var_reg;
        out_nis_next   = out_nis_reg;
        out_err_next   = out_err_reg;
        mul_a          = mag_reg;
        mul_b          = {15'd0, k_reg};
        s_axis_tready  = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    nis_next   = 32'd0;
                    err_next   = 1'b0;
                    state_next = ST_DONE;
                    if (s_axis_tuser == KIND_PREDICT)
                    begin
                        var_next = pred_sum[32] ? 32'hFFFF_FFFF : pred_sum[31:0];
                    end
                    else if (s_sum == 33'd0)
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        s_next     = s_sum;
                        neg_next   = innov[32];
                        mag_next   = innov[32] ? innov_neg[31:0] : innov[31:0];
                        // P<<16 / S: top part P>>1 is already below S
                        rem_next   = {2'b00, var_reg[31:1]};
                        dsr_next   = {var_reg[0], 63'd0};
                        quo_next   = 32'd0;
                        cnt_next   = K_STEPS;
                        state_next = ST_DIV_K;
                    end
                end
            end
            ST_DIV_K:
            begin
                if (cnt_reg == CNT_W'(1))
                begin
                    k_next     = quo_next[16:0];
                    state_next = ST_MUL_STEP;
                end
            end
            ST_MUL_STEP:
            begin
                state_next = ST_MUL_VAR;
            end
            ST_MUL_VAR:
            begin
                if (est_sum[33:31] == 3'b000 || est_sum[33:31] == 3'b111)
                    est_next = est_sum[31:0];
                else
                    est_next = est_sum[33] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                mul_a      = var_reg;
                mul_b      = {15'd0, one_minus_k};
                state_next = ST_MUL_NIS;
            end
            ST_MUL_NIS:
            begin
                var_next   = prod_reg[47:16];
                mul_b      = mag_reg;
                state_next = ST_NIS_CHK;
            end
            ST_NIS_CHK:
            begin
                // quotient needs more than 32 bits when the top half reaches S
                if ({1'b0, prod_reg[63:32]} >= s_reg)
                begin
                    nis_next   = 32'hFFFF_FFFF;
                    state_next = ST_DONE;
                end
                else
                begin
                    rem_next   = {1'b0, prod_reg[63:32]};
                    dsr_next   = {prod_reg[31:0], 32'd0};
                    quo_next   = 32'd0;
                    cnt_next   = NIS_STEPS;
                    state_next = ST_DIV_NIS;
                end
            end
            ST_DIV_NIS:
            begin
                if (cnt_reg == CNT_W'(1))
                begin
                    nis_next   = quo_next;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_est_next   = est_reg;
                    out_var_next   = var_reg;
                    out_nis_next   = nis_reg;
                    out_err_next   = err_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pn_reg        <= PROCESS_NOISE_RST;
            est_reg       <= 32'd0;
            var_reg       <= VARIANCE_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pn_reg        <= pn_next;
            est_reg       <= est_next;
            var_reg       <= var_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg       <= s_next;
        mag_reg     <= mag_next;
        neg_reg     <= neg_next;
        k_reg       <= k_next;
        rem_reg     <= rem_next;
        dsr_reg     <= dsr_next;
        quo_reg     <= quo_next;
        cnt_reg     <= cnt_next;
        prod_reg    <= mul_a * mul_b;
        nis_reg     <= nis_next;
        err_reg     <= err_next;
        out_est_reg <= out_est_next;
        out_var_reg <= out_var_next;
        out_nis_reg <= out_nis_next;
        out_err_reg <= out_err_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_nis_reg, out_var_reg, out_est_reg};
    assign m_axis_tuser  = out_err_reg;

endmodule

[sv/skf_checker.sv]
// ----------------------------------------------------------------------------
// skf_checker
// Port-level checks on the scalar Kalman filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "scalar_kalman_filter_top_assert.svh"

module skf_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [skf_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic                          m_axis_tuser
);
    import skf_pkg::*;

    logic in_xfer;
    logic err_shown;

    assign in_xfer   = s_axis_tvalid && s_axis_tready;
    assign err_shown = m_axis_tvalid && m_axis_tuser;

    // one item at a time: busy right after an input transfer
    `SKF_ASSERT_NXT(a_busy_after_in, in_xfer, !s_axis_tready, "ready straight after transfer")

    // no result is valid in the cycle after taking an item when none was pending
    `SKF_ASSERT_NXT(a_no_early_out, in_xfer && !m_axis_tvalid, !m_axis_tvalid,
                    "result too early")

    // a skipped update reports zero NIS
    `SKF_ASSERT_IMP(a_err_nis_zero, err_shown, m_axis_tdata[NIS_LSB +: 32] == 32'd0,
                    "error with nonzero nis")

    `SKF_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
                    "stalled result changed")

endmodule

bind scalar_kalman_filter_top skf_checker u_skf_checker (.*);
